/* hdl/qlw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlw_pkg
// Shared sizes, command codes, item types and helpers of the frame list walker.
// ----------------------------------------------------------------------------
package qlw_pkg;

  localparam int LEVELS  = 8;
  localparam int ENTRIES = 1024;

  localparam int CMD_W = 3;
  localparam int LVL_W = 3;
  localparam int POS_W = 11;
  localparam int FR_W  = 16;
  localparam int CNT_W = 4;

  localparam int LV_IW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = $clog2(LEVELS * ENTRIES);
  localparam int ENT_W  = 3 * FR_W;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BETTER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WORSE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] entry_index;
    logic [FR_W-1:0]  frame_in;
    logic [FR_W-1:0]  start_in;
    logic [FR_W-1:0]  end_in;
  } item_t;

  typedef struct packed {
    logic [FR_W-1:0]  frame_out;
    logic [FR_W-1:0]  start_out;
    logic [FR_W-1:0]  end_out;
    logic [LVL_W-1:0] level_now;
    logic [POS_W-1:0] position_now;
    logic             exhausted;
    logic [FR_W-1:0]  greatest_end;
    logic             level_changed;
  } res_t;

  function automatic logic is_exh(input logic [POS_W-1:0] pos,
                                  input logic [POS_W-1:0] size,
                                  input logic [LVL_W-1:0] lvl);
    return (pos >= size) || (32'(pos) >= ENTRIES) || (32'(lvl) >= LEVELS);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
    return ADDR_W'(32'(lvl) * ENTRIES + 32'(pos));
  endfunction

endpackage

/* hdl/qlw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qlw_ram #(
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/qlw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlw_ctrl
// Command sequencer: level sizes, play position, level search, result build.
// ----------------------------------------------------------------------------
module qlw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qlw_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qlw_pkg::item_t                in_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output qlw_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [qlw_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [qlw_pkg::ENT_W-1:0]     ram_wdata,
  output logic                          ram_re,
  output logic [qlw_pkg::ADDR_W-1:0]    ram_raddr,
  input  logic [qlw_pkg::ENT_W-1:0]     ram_rdata
);

  import qlw_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_SW_EXH   = 3'd2;
  localparam logic [2:0] ST_SW_TGT   = 3'd3;
  localparam logic [2:0] ST_SRCH_RD  = 3'd4;
  localparam logic [2:0] ST_SRCH_CMP = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;
  localparam logic [2:0] ST_RESP     = 3'd7;

  logic [2:0]       state;
  item_t            cur;
  logic [LVL_W-1:0] lvl;
  logic [POS_W-1:0] pos;
  logic [FR_W-1:0]  max_end;
  logic             changed;
  logic [CNT_W-1:0] level_count;
  logic [POS_W-1:0] sizes [LEVELS];
  logic [LVL_W-1:0] new_lvl;
  logic [FR_W-1:0]  target;
  logic [POS_W-1:0] pos_s;

  logic [LVL_W-1:0] size_lv;
  logic [POS_W-1:0] size_sel;
  logic             exh_cur;
  logic             exh_adv;
  logic             srch_end;
  logic [POS_W-1:0] pos_adv;
  logic [CNT_W:0]   lim;
  logic             worse_ok;
  logic             load_ok;
  logic             count_ok;
  logic [FR_W-1:0]  rd_frame;
  logic [FR_W-1:0]  rd_start;
  logic [FR_W-1:0]  rd_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESP);

  assign size_lv  = (state == ST_SW_EXH || state == ST_SRCH_RD || state == ST_SRCH_CMP)
                    ? new_lvl : lvl;
  assign size_sel = (32'(size_lv) < LEVELS) ? sizes[LV_IW'(size_lv)] : '0;
  assign exh_cur  = is_exh(pos, size_sel, lvl);
  assign pos_adv  = pos + 1'b1;
  assign exh_adv  = is_exh(pos_adv, size_sel, lvl);
  assign srch_end = is_exh(pos_s, size_sel, new_lvl);

  always_comb begin
    lim = (CNT_W + 1)'(level_count);
    if (32'(lim) > LEVELS) begin
      lim = (CNT_W + 1)'(LEVELS);
    end
    if (lim > (CNT_W + 1)'(8)) begin
      lim = (CNT_W + 1)'(8);
    end
  end

  assign worse_ok = ((CNT_W + 1)'(lvl) + 1'b1) < lim;
  assign load_ok  = (32'(cur.level) < LEVELS) && (32'(cur.entry_index) < ENTRIES);
  assign count_ok = (32'(cur.level) < LEVELS);

  assign rd_frame = ram_rdata[FR_W-1:0];
  assign rd_start = ram_rdata[2*FR_W-1:FR_W];
  assign rd_end   = ram_rdata[3*FR_W-1:2*FR_W];

  assign ram_we    = (state == ST_EXEC) && (cur.cmd == CMD_LOAD) && load_ok;
  assign ram_waddr = slot_addr(cur.level, cur.entry_index);
  assign ram_wdata = {cur.end_in, cur.start_in, cur.frame_in};

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = slot_addr(lvl, pos);
    case (state)
      ST_EXEC: begin
        ram_re = (cur.cmd == CMD_BETTER) || (cur.cmd == CMD_WORSE);
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_SRCH_RD: begin
        ram_re    = !srch_end;
        ram_raddr = slot_addr(new_lvl, pos_s);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.frame_out     = exh_cur ? '0 : rd_frame;
    res.start_out     = exh_cur ? '0 : rd_start;
    res.end_out       = exh_cur ? '0 : rd_end;
    res.level_now     = lvl;
    res.position_now  = pos;
    res.exhausted     = exh_cur;
    res.greatest_end  = max_end;
    res.level_changed = changed;
    if (cur.cmd == CMD_NEXT && !exh_cur) begin
      res.position_now = pos_adv;
      res.exhausted    = exh_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cur <= in_item;
    end
    if (state == ST_SW_TGT) begin
      target <= rd_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      lvl         <= '0;
      pos         <= '0;
      max_end     <= '0;
      changed     <= 1'b0;
      level_count <= CNT_W'(1);
      new_lvl     <= '0;
      pos_s       <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        sizes[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        level_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            changed <= 1'b0;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_READ;
          case (cur.cmd)
            CMD_CLEAR: begin
              lvl     <= '0;
              pos     <= '0;
              max_end <= '0;
            end
            CMD_COUNT: begin
              if (count_ok) begin
                sizes[LV_IW'(cur.level)] <= (32'(cur.entry_index) > ENTRIES)
                                            ? POS_W'(ENTRIES) : cur.entry_index;
              end
            end
            CMD_LOAD: begin
              if (load_ok && cur.end_in > max_end) begin
                max_end <= cur.end_in;
              end
            end
            CMD_BETTER: begin
              if (lvl != '0) begin
                new_lvl <= lvl - 1'b1;
                state   <= exh_cur ? ST_SW_EXH : ST_SW_TGT;
              end
            end
            CMD_WORSE: begin
              if (worse_ok) begin
                new_lvl <= lvl + 1'b1;
                state   <= exh_cur ? ST_SW_EXH : ST_SW_TGT;
              end
            end
            default: begin
              state <= ST_READ;
            end
          endcase
        end
        ST_SW_EXH: begin
          lvl     <= new_lvl;
          pos     <= size_sel;
          changed <= 1'b1;
          state   <= ST_READ;
        end
        ST_SW_TGT: begin
          pos_s <= '0;
          state <= ST_SRCH_RD;
        end
        ST_SRCH_RD: begin
          if (srch_end) begin
            lvl     <= new_lvl;
            pos     <= pos_s;
            changed <= 1'b1;
            state   <= ST_READ;
          end else begin
            state <= ST_SRCH_CMP;
          end
        end
        ST_SRCH_CMP: begin
          if (rd_frame < target) begin
            pos_s <= pos_s + 1'b1;
            state <= ST_SRCH_RD;
          end else begin
            lvl     <= new_lvl;
            pos     <= pos_s;
            changed <= 1'b1;
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready) begin
            if (cur.cmd == CMD_NEXT && !exh_cur) begin
              pos <= pos_adv;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/qlw_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlw_out
// Output register for result items; frees the sequencer while a result waits.
// ----------------------------------------------------------------------------
module qlw_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  qlw_pkg::res_t                     res,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [qlw_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  import qlw_pkg::*;

  res_t hold;

  assign res_ready = !m_tvalid || m_tready;

  assign m_tdata = {hold.level_changed, hold.greatest_end, hold.exhausted,
                    hold.position_now, hold.level_now, hold.end_out,
                    hold.start_out, hold.frame_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold <= res;
    end
  end

endmodule

/* hdl/quality_level_frame_list_walker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_level_frame_list_walker_core
// Key frame table walker over several quality levels, one result per command.
// ----------------------------------------------------------------------------
// Every command gives exactly one result item. Clear, set count, load, next,
// unknown commands and level switches refused at a level bound pass through
// the execute, read and response states; a level switch from an exhausted
// position adds a switch state before the read. A level switch that searches
// first reads the current frame, then steps through the new level's entries
// until it stops on an entry at or past the current frame or runs to the new
// level's count; each search step is a read of the single-read-port entry
// RAM followed by a compare. The entry RAM is not cleared at reset; entries
// read before being loaded are undefined. The result register lets a new
// item be accepted while the previous result is still waiting on the master
// side.
module quality_level_frame_list_walker_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qlw_pkg::CNT_W-1:0]        cfg_data,    // level_count
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // level, entry_index, frame_in, start_in, end_in, 2 bits zero
  input  logic [qlw_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic [qlw_pkg::IN_TUSER_W-1:0]   s_tuser,     // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // frame_out, start_out, end_out, level_now, position_now, exhausted,
  // greatest_end, level_changed
  output logic [qlw_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  import qlw_pkg::*;

  item_t             in_item;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  assign in_item.cmd         = s_tuser;
  assign in_item.level       = s_tdata[2:0];
  assign in_item.entry_index = s_tdata[13:3];
  assign in_item.frame_in    = s_tdata[29:14];
  assign in_item.start_in    = s_tdata[45:30];
  assign in_item.end_in      = s_tdata[61:46];

  qlw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  qlw_ram #(
    .WIDTH  (ENT_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qlw_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* hdl/qlw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlw_checker
// Port-level checks of the frame list walker, bound to the top level.
// ----------------------------------------------------------------------------
module qlw_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [qlw_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  import qlw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[61:51]) <= ENTRIES)
    else $error("position beyond entry count");

endmodule

bind quality_level_frame_list_walker_core qlw_checker u_qlw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
